// ===== rtl/rgbhsv_pkg.sv =====
// types and constants shared by the rgb to hsv converter
package rgbhsv_pkg;

    // channel that holds the maximum, red wins ties, then green
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // hue numerator offsets in units of chroma
    localparam logic [2:0] HUE_OFS_NONE  = 3'd0;
    localparam logic [2:0] HUE_OFS_GREEN = 3'd2;
    localparam logic [2:0] HUE_OFS_BLUE  = 3'd4;
    localparam logic [2:0] HUE_OFS_TURN  = 3'd6;

    // register stages ahead of the divider stages
    localparam int PRE_STAGES = 3;

endpackage

// ===== rtl/rgb_to_hsv_converter_core.sv =====
// rgb to hsv converter: pipelined sector logic and two restoring dividers
//
// Input channel: i_in_valid / o_in_ready carry one rgb pixel (i_red, i_green,
// i_blue). Output channel: o_out_valid / i_out_ready carry one hsv result
// (o_hue, o_saturation, o_value_out) per pixel, in input order.
// Three stages find max, min, chroma and the hue numerator, then
// FRACTION_BITS stages each produce one quotient bit of hue and of
// saturation in parallel. Throughput is one item per cycle while the
// receiver does not stall, as the dividers produce one bit per stage.
// Each stage has its own valid bit and advances when it is empty or the
// stage after it advances, so bubbles close up while the receiver stalls and
// new items keep entering until every stage is full. A stall loses nothing.
// Reset clears all valid bits; the pipeline is then empty and ready.
// Saturation is all ones when chroma equals the nonzero value, zero for black;
// hue is zero for gray pixels.
module rgb_to_hsv_converter_core
    import rgbhsv_pkg::*;
#(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [CHANNEL_BITS-1:0]  i_red,
    input  logic [CHANNEL_BITS-1:0]  i_green,
    input  logic [CHANNEL_BITS-1:0]  i_blue,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [FRACTION_BITS-1:0] o_hue,
    output logic [FRACTION_BITS-1:0] o_saturation,
    output logic [CHANNEL_BITS-1:0]  o_value_out
);

    localparam int CB = CHANNEL_BITS;
    localparam int FB = FRACTION_BITS;
    localparam int HW = CB + 3;
    localparam int NS = PRE_STAGES + FB;

    logic [NS-1:0] r_valid;
    logic [NS:0]   adv;

    // stage 0: max, min, sector
    logic [CB-1:0] r0_r, r0_g, r0_b, r0_max, r0_min;
    t_sector       r0_sec;
    t_sector       n0_sec;
    logic [CB-1:0] n0_max, n0_min;

    // stage 1: chroma, channel difference, offset
    logic [CB-1:0] r1_v, r1_chroma;
    logic signed [CB:0] r1_diff;
    logic [2:0]    r1_k;
    logic signed [CB:0] n1_diff;
    logic [2:0]    n1_k;

    // stage 2 (index 0) and divider stages (index 1..FB)
    logic [HW-1:0] r_hr [0:FB];
    logic [HW-1:0] r_hd [0:FB];
    logic [FB-1:0] r_hq [0:FB];
    logic [CB-1:0] r_sr [0:FB];
    logic [CB-1:0] r_sd [0:FB];
    logic [FB-1:0] r_sq [0:FB];
    logic [CB-1:0] r_v  [0:FB];
    logic          r_sfull [0:FB];

    logic [HW-1:0] n2_off, n2_den;
    logic [HW:0]   n2_num;

    // stage handshake chain
    assign adv[NS] = i_out_ready;
    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_adv
            assign adv[s] = !r_valid[s] || adv[s+1];
        end
    endgenerate

    assign o_in_ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (adv[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // stage 0
    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n0_sec = SEC_RED;
            n0_max = i_red;
        end else if (i_green >= i_blue) begin
            n0_sec = SEC_GREEN;
            n0_max = i_green;
        end else begin
            n0_sec = SEC_BLUE;
            n0_max = i_blue;
        end
        if (i_red <= i_green && i_red <= i_blue) begin
            n0_min = i_red;
        end else if (i_green <= i_blue) begin
            n0_min = i_green;
        end else begin
            n0_min = i_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_r   <= i_red;
            r0_g   <= i_green;
            r0_b   <= i_blue;
            r0_max <= n0_max;
            r0_min <= n0_min;
            r0_sec <= n0_sec;
        end
    end

    // stage 1
    always_comb begin
        case (r0_sec)
            SEC_RED: begin
                n1_diff = $signed({1'b0, r0_g}) - $signed({1'b0, r0_b});
                n1_k    = (r0_g < r0_b) ? HUE_OFS_TURN : HUE_OFS_NONE;
            end
            SEC_GREEN: begin
                n1_diff = $signed({1'b0, r0_b}) - $signed({1'b0, r0_r});
                n1_k    = HUE_OFS_GREEN;
            end
            SEC_BLUE: begin
                n1_diff = $signed({1'b0, r0_r}) - $signed({1'b0, r0_g});
                n1_k    = HUE_OFS_BLUE;
            end
            default: begin
                n1_diff = '0;
                n1_k    = HUE_OFS_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_v      <= r0_max;
            r1_chroma <= r0_max - r0_min;
            r1_diff   <= n1_diff;
            r1_k      <= n1_k;
        end
    end

    // stage 2: hue numerator and denominator, saturation operands
    always_comb begin
        n2_off = HW'(r1_chroma) * HW'(r1_k);
        n2_den = HW'(r1_chroma) * HW'(HUE_OFS_TURN);
        n2_num = {1'b0, n2_off} + {{3{r1_diff[CB]}}, r1_diff};
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_hr[0]    <= n2_num[HW-1:0];
            r_hd[0]    <= (r1_chroma == '0) ? HW'(1) : n2_den;
            r_hq[0]    <= '0;
            r_sr[0]    <= (r1_chroma == r1_v) ? '0 : r1_chroma;
            r_sd[0]    <= (r1_v == '0) ? CB'(1) : r1_v;
            r_sq[0]    <= '0;
            r_v[0]     <= r1_v;
            r_sfull[0] <= (r1_chroma == r1_v) && (r1_v != '0);
        end
    end

    // divider stages, one quotient bit each
    genvar j;
    generate
        for (j = 0; j < FB; j++) begin : g_div
            logic [HW:0]   n_ht;
            logic [HW:0]   n_hs;
            logic          n_hbit;
            logic [CB:0]   n_st;
            logic [CB:0]   n_ss;
            logic          n_sbit;

            assign n_ht   = {r_hr[j], 1'b0};
            assign n_hs   = n_ht - {1'b0, r_hd[j]};
            assign n_hbit = (n_ht >= {1'b0, r_hd[j]});
            assign n_st   = {r_sr[j], 1'b0};
            assign n_ss   = n_st - {1'b0, r_sd[j]};
            assign n_sbit = (n_st >= {1'b0, r_sd[j]});

            always_ff @(posedge i_clk) begin
                if (adv[PRE_STAGES+j]) begin
                    r_hr[j+1]    <= n_hbit ? n_hs[HW-1:0] : n_ht[HW-1:0];
                    r_hd[j+1]    <= r_hd[j];
                    r_hq[j+1]    <= {r_hq[j][FB-2:0], n_hbit};
                    r_sr[j+1]    <= n_sbit ? n_ss[CB-1:0] : n_st[CB-1:0];
                    r_sd[j+1]    <= r_sd[j];
                    r_sq[j+1]    <= {r_sq[j][FB-2:0], n_sbit};
                    r_v[j+1]     <= r_v[j];
                    r_sfull[j+1] <= r_sfull[j];
                end
            end
        end
    endgenerate

    assign o_out_valid  = r_valid[NS-1];
    assign o_hue        = r_hq[FB];
    assign o_saturation = r_sfull[FB] ? '1 : r_sq[FB];
    assign o_value_out  = r_v[FB];

`ifndef SYNTHESIS
    a_black_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_value_out == '0) |-> (o_hue == '0 && o_saturation == '0))
        else $error("black pixel with nonzero hue or saturation");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_valid[0])
        else $error("accepted item missing from first stage");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule
